[rtl/spfe_pkg.sv]
// Package of shared types, codes and sizes for the softened potential field evaluator.
`timescale 1ns / 1ps
package spfe_pkg;

  localparam int MaxMasses = 64;
  localparam int IdxW      = $clog2(MaxMasses);
  localparam int CountW    = $clog2(MaxMasses + 1);
  localparam int EntryW    = 48;
  localparam logic [15:0] EpsReset = 16'd1311;

  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActAdd   = 2'd1,
    ActQuery = 2'd2,
    ActOther = 2'd3
  } spfe_action_e;

  typedef enum logic [1:0] {
    StsAnswered = 2'd0,
    StsStored   = 2'd1,
    StsFull     = 2'd2,
    StsCleared  = 2'd3
  } spfe_status_e;

  typedef enum logic [4:0] {
    StIdle, StLoad, StRootIn, StRoot, StHeight, StCosX, StCosY,
    StMulX, StSlopeX, StMulY, StSlopeY, StNext,
    StSat, StNormSq, StNormRoot, StNormX, StNormY, StNormZ, StOut
  } spfe_state_e;

  typedef struct packed {
    logic [1:0]   action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]  mass_weight;
  } spfe_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] height;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
    logic [6:0]         mass_count;
  } spfe_out_t;

endpackage

[rtl/spfe_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module spfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/softened_potential_field_eval_core.sv]
// Top level of the softened potential field evaluator: mass table, sequencer and arithmetic.
`timescale 1ns / 1ps
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------
// input    | in        | in_valid_i/in_ready_o  | in_data_i  (spfe_in_t)
// output   | out       | out_valid_o/out_ready_i| out_data_o (spfe_out_t)
// config   | in        | cfg_we_i               | cfg_wdata_i (epsilon)
//
// A clear or add item is handled in the idle state and its result goes straight into the output
// register. A query walks every stored mass through the bit-serial square root and divider
// (a mass at zero distance skips the slope steps), then normalises with the same units.
// Reset zeroes the mass count, restores the default epsilon and idles the sequencer;
// the table itself is not cleared. Input is taken only while the sequencer is idle
// and the output register is free or being emptied in the same cycle.
module softened_potential_field_eval_core
  import spfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  spfe_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output spfe_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  spfe_state_e state_q, state_d;

  // Mass table: {x, y, weight} in one word.
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [15:0]       eps_q;

  logic signed [15:0] qx_q, qy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [15:0]        adx_q, ady_q, w_q;
  logic [21:0]        r_q;
  logic [22:0]        s_q;
  logic [36:0]        hm_q;
  logic [17:0]        cx_q, cy_q;
  logic [54:0]        prod_q;
  logic signed [63:0] acc_h_q, acc_x_q, acc_y_q;
  logic signed [31:0] h_sat_q, gx_sat_q, gy_sat_q;
  logic [63:0]        sqx_q, sqy_q;
  logic [31:0]        len_q;
  logic signed [15:0] nx_q, ny_q;
  logic [14:0]        nz_q;

  logic      out_valid_q;
  spfe_out_t out_data_q;
  spfe_out_t ack_data;

  // Bit-serial divider with rounding to nearest.
  logic        div_run_q;
  logic [6:0]  div_cnt_q;
  logic [63:0] div_num_q, div_quo_q;
  logic [31:0] div_rem_q, div_den_q;
  logic        div_load, div_take, div_done;
  logic [63:0] div_raw;
  logic [31:0] div_den_raw, div_den_fix;
  logic [6:0]  div_bits;
  logic [63:0] div_aligned;
  logic [32:0] div_rem_sh;
  logic        div_qbit;

  // Bit-serial square root.
  logic        sq_run_q;
  logic [5:0]  sq_cnt_q;
  logic [63:0] sq_rem_q, sq_res_q, sq_bit_q;
  logic        sq_load, sq_take, sq_done;
  logic [63:0] sq_arg, sq_trial;

  logic        accept;
  spfe_in_t    in_d;
  logic signed [16:0] dx_c, dy_c;
  logic [31:0] ax_c, ay_c;
  logic [55:0] tmag;
  logic [15:0] nmag;

  assign in_d        = in_data_i;
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign div_done = div_run_q && (div_cnt_q == 7'd0);
  assign sq_done  = sq_run_q && (sq_cnt_q == 6'd0);

  spfe_ram #(.Width(EntryW), .Depth(MaxMasses)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The table is read every cycle at the index of the next cycle, so the entry
  // for idx_q is on the read port while the sequencer sits in the load state.
  assign ram_raddr = idx_d[IdxW-1:0];
  assign ram_waddr = count_q[IdxW-1:0];
  assign ram_wdata = {in_d.pos_x, in_d.pos_y, in_d.mass_weight};
  assign ram_we    = accept && (in_d.action == ActAdd) && (count_q < CountW'(MaxMasses));

  assign dx_c = 17'(signed'(qx_q)) - 17'(signed'(ram_rdata[47:32]));
  assign dy_c = 17'(signed'(qy_q)) - 17'(signed'(ram_rdata[31:16]));
  assign ax_c = gx_sat_q[31] ? (~gx_sat_q + 32'd1) : gx_sat_q;
  assign ay_c = gy_sat_q[31] ? (~gy_sat_q + 32'd1) : gy_sat_q;
  assign tmag = div_quo_q[55:0];
  assign nmag = div_quo_q[15:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (in_d.action != ActClear) && (in_d.action != ActAdd)) begin
          state_d = (count_q == '0) ? StSat : StLoad;
        end
      end
      StLoad:     state_d = StRootIn;
      StRootIn:   state_d = StRoot;
      StRoot:     if (sq_done) state_d = StHeight;
      StHeight: begin
        if (div_done) state_d = (r_q == '0) ? StNext : StCosX;
      end
      StCosX:     if (div_done) state_d = StCosY;
      StCosY:     if (div_done) state_d = StMulX;
      StMulX:     state_d = StSlopeX;
      StSlopeX:   if (div_done) state_d = StMulY;
      StMulY:     state_d = StSlopeY;
      StSlopeY:   if (div_done) state_d = StNext;
      StNext:     state_d = (idx_q + CountW'(1) == count_q) ? StSat : StLoad;
      StSat:      state_d = StNormSq;
      StNormSq:   state_d = StNormRoot;
      StNormRoot: if (sq_done) state_d = StNormX;
      StNormX:    if (div_done) state_d = StNormY;
      StNormY:    if (div_done) state_d = StNormZ;
      StNormZ:    if (div_done) state_d = StOut;
      StOut:      if (!out_valid_q || out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // Control outputs of the sequencer: operand selection for the shared units and the next table index.
  always_comb begin
    div_raw     = '0;
    div_den_raw = '0;
    div_bits    = 7'd0;
    sq_arg      = '0;
    sq_load     = 1'b0;
    idx_d       = idx_q;
    unique case (state_q)
      StIdle:     if (accept) idx_d = '0;
      StHeight: begin
        div_raw     = {28'd0, w_q, 20'd0};
        div_den_raw = {9'd0, s_q};
        div_bits    = 7'd40;
      end
      StCosX: begin
        div_raw     = {28'd0, adx_q, 20'd0};
        div_den_raw = {10'd0, r_q};
        div_bits    = 7'd40;
      end
      StCosY: begin
        div_raw     = {28'd0, ady_q, 20'd0};
        div_den_raw = {10'd0, r_q};
        div_bits    = 7'd40;
      end
      StSlopeX, StSlopeY: begin
        div_raw     = {9'd0, prod_q};
        div_den_raw = {9'd0, s_q};
        div_bits    = 7'd56;
      end
      StNormX: begin
        div_raw     = {18'd0, ax_c, 14'd0};
        div_den_raw = len_q;
        div_bits    = 7'd48;
      end
      StNormY: begin
        div_raw     = {18'd0, ay_c, 14'd0};
        div_den_raw = len_q;
        div_bits    = 7'd48;
      end
      StNormZ: begin
        div_raw     = 64'd1 << 30;
        div_den_raw = len_q;
        div_bits    = 7'd32;
      end
      StRootIn: begin
        sq_load = 1'b1;
        sq_arg  = {22'd0, ({2'd0, 32'(adx_q) * 32'(adx_q)}
                         + {2'd0, 32'(ady_q) * 32'(ady_q)}), 8'd0};
      end
      StNormSq:   ;
      StNormRoot: begin
        sq_load = !sq_run_q;
        sq_arg  = sqx_q + sqy_q + (64'd1 << 32);
      end
      StNext:     idx_d = idx_q + CountW'(1);
      default:    ;
    endcase
    div_load = (div_bits != 7'd0) && !div_run_q;
    div_take = (div_bits != 7'd0) && div_done;
    sq_take  = ((state_q == StRoot) || (state_q == StNormRoot)) && sq_done;
  end

  assign div_den_fix = (div_den_raw == '0) ? 32'd1 : div_den_raw;
  assign div_aligned = (div_raw + {33'd0, div_den_fix[31:1]}) << (7'd64 - div_bits);
  assign div_rem_sh  = {div_rem_q, div_num_q[63]};
  assign div_qbit    = (div_rem_sh >= {1'b0, div_den_q});
  assign sq_trial    = sq_res_q + sq_bit_q;

  // Shared arithmetic units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
      div_cnt_q <= '0;
      sq_run_q  <= 1'b0;
      sq_cnt_q  <= '0;
    end else begin
      if (div_load) begin
        div_run_q <= 1'b1;
        div_cnt_q <= div_bits;
      end else if (div_run_q && (div_cnt_q != 7'd0)) begin
        div_cnt_q <= div_cnt_q - 7'd1;
      end else if (div_take) begin
        div_run_q <= 1'b0;
      end
      if (sq_load) begin
        sq_run_q <= 1'b1;
        sq_cnt_q <= 6'd32;
      end else if (sq_run_q && (sq_cnt_q != 6'd0)) begin
        sq_cnt_q <= sq_cnt_q - 6'd1;
      end else if (sq_take) begin
        sq_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      div_num_q <= div_aligned;
      div_den_q <= div_den_fix;
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (div_run_q && (div_cnt_q != 7'd0)) begin
      div_num_q <= {div_num_q[62:0], 1'b0};
      div_quo_q <= {div_quo_q[62:0], div_qbit};
      div_rem_q <= div_qbit ? 32'(div_rem_sh - {1'b0, div_den_q}) : div_rem_sh[31:0];
    end
    if (sq_load) begin
      sq_rem_q <= sq_arg;
      sq_res_q <= '0;
      sq_bit_q <= 64'd1 << 62;
    end else if (sq_run_q && (sq_cnt_q != 6'd0)) begin
      if (sq_rem_q >= sq_trial) begin
        sq_rem_q <= sq_rem_q - sq_trial;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // Control registers.
  always_comb begin
    count_d = count_q;
    if (accept && (in_d.action == ActClear)) begin
      count_d = '0;
    end else if (ram_we) begin
      count_d = count_q + CountW'(1);
    end
  end

  // Result of a clear or add item: every field but the status and the count is zero.
  always_comb begin
    ack_data            = '0;
    ack_data.status     = (in_d.action == ActClear) ? StsCleared :
                          (ram_we ? StsStored : StsFull);
    ack_data.mass_count = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      eps_q       <= EpsReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (accept && ((in_d.action == ActClear) || (in_d.action == ActAdd))) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == StOut) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Query datapath and result register.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        qx_q    <= in_d.pos_x;
        qy_q    <= in_d.pos_y;
        acc_h_q <= '0;
        acc_x_q <= '0;
        acc_y_q <= '0;
        if (accept && ((in_d.action == ActClear) || (in_d.action == ActAdd))) begin
          out_data_q <= ack_data;
        end
      end
      StLoad: begin
        dx_q  <= dx_c;
        dy_q  <= dy_c;
        adx_q <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
        ady_q <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
        w_q   <= ram_rdata[15:0];
      end
      StRoot: begin
        if (sq_done) begin
          r_q <= sq_res_q[21:0];
          s_q <= 23'(sq_res_q[21:0]) + 23'(eps_q);
        end
      end
      StHeight: begin
        if (div_done) begin
          hm_q    <= div_quo_q[36:0];
          acc_h_q <= acc_h_q - $signed({27'd0, div_quo_q[36:0]});
        end
      end
      StCosX:   if (div_done) cx_q <= div_quo_q[17:0];
      StCosY:   if (div_done) cy_q <= div_quo_q[17:0];
      StMulX:   prod_q <= 55'(hm_q) * 55'(cx_q);
      StMulY:   prod_q <= 55'(hm_q) * 55'(cy_q);
      StSlopeX: begin
        if (div_done) begin
          acc_x_q <= dx_q[16] ? acc_x_q - $signed({8'd0, tmag})
                              : acc_x_q + $signed({8'd0, tmag});
        end
      end
      StSlopeY: begin
        if (div_done) begin
          acc_y_q <= dy_q[16] ? acc_y_q - $signed({8'd0, tmag})
                              : acc_y_q + $signed({8'd0, tmag});
        end
      end
      StSat: begin
        h_sat_q  <= (acc_h_q > 64'sd2147483647) ? 32'sh7FFFFFFF :
                    (acc_h_q < -64'sd2147483648) ? 32'sh80000000 : acc_h_q[31:0];
        gx_sat_q <= (acc_x_q > 64'sd2147483647) ? 32'sh7FFFFFFF :
                    (acc_x_q < -64'sd2147483648) ? 32'sh80000000 : acc_x_q[31:0];
        gy_sat_q <= (acc_y_q > 64'sd2147483647) ? 32'sh7FFFFFFF :
                    (acc_y_q < -64'sd2147483648) ? 32'sh80000000 : acc_y_q[31:0];
      end
      StNormSq: begin
        sqx_q <= 64'(ax_c) * 64'(ax_c);
        sqy_q <= 64'(ay_c) * 64'(ay_c);
      end
      StNormRoot: if (sq_done) len_q <= sq_res_q[31:0];
      StNormX:  if (div_done) nx_q <= gx_sat_q[31] ? nmag : -nmag;
      StNormY:  if (div_done) ny_q <= gy_sat_q[31] ? nmag : -nmag;
      StNormZ:  if (div_done) nz_q <= div_quo_q[14:0];
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_q.status     <= StsAnswered;
          out_data_q.height     <= h_sat_q;
          out_data_q.slope_x    <= gx_sat_q;
          out_data_q.slope_y    <= gy_sat_q;
          out_data_q.normal_x   <= nx_q;
          out_data_q.normal_y   <= ny_q;
          out_data_q.normal_z   <= nz_q;
          out_data_q.mass_count <= 7'(count_q);
        end
      end
      default: ;
    endcase
  end

endmodule
